### src/ehfp_pkg.sv
// Shared types and constants for the ETag header field parser.
package ehfp_pkg;

  // Final status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNotEtag = 2'd1;
  localparam logic [1:0] StBad     = 2'd2;
  localparam logic [1:0] StLong    = 2'd3;

  // Result kinds
  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Characters
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] CaseBit = 8'h20;

  localparam int unsigned LenW = 6;
  localparam logic [LenW-1:0] LenMax = 6'd63;
  localparam logic [LenW-1:0] LimitReset = 6'd63;

  typedef struct packed {
    logic            kind;
    logic [7:0]      vbyte;
    logic [1:0]      status;
    logic [LenW-1:0] len;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;   // number of results this byte produced (0..2)
    result_t    res0;
    result_t    res1;
  } push_t;

  // Lower case key character at a given position of "etag"
  function automatic logic [7:0] key_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0: c = 8'h65;
      2'd1: c = 8'h74;
      2'd2: c = 8'h61;
      default: c = 8'h67;
    endcase
    return c;
  endfunction

endpackage

### src/ehfp_parse_core.sv
// Parser state registers and per-byte decode logic.
module ehfp_parse_core #(
  parameter int unsigned VALUE_STORE_BYTES = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic [7:0]               byte_i,
  input  logic                     line_end_i,
  input  logic [ehfp_pkg::LenW-1:0] max_len_i,
  output ehfp_pkg::push_t          push_o
);
  import ehfp_pkg::*;

  localparam int unsigned StoreLimitInt =
    (VALUE_STORE_BYTES - 1 > 63) ? 63 : VALUE_STORE_BYTES - 1;
  localparam logic [LenW-1:0] StoreLimit = LenW'(StoreLimitInt);

  localparam logic [2:0] PhKey   = 3'd0;
  localparam logic [2:0] PhPre   = 3'd1;
  localparam logic [2:0] PhPost  = 3'd2;
  localparam logic [2:0] PhValue = 3'd3;
  localparam logic [2:0] PhDone  = 3'd4;

  logic [2:0]      phase_q, phase_d;
  logic [1:0]      key_pos_q, key_pos_d;
  logic [LenW-1:0] count_q, count_d;

  logic            ws;
  logic            final_done;
  logic            have_a;
  result_t         res_a;
  result_t         res_e;
  logic [LenW-1:0] limit;

  always_comb begin
    ws    = (byte_i == ChSpace) || (byte_i == ChTab);
    limit = (max_len_i < StoreLimit) ? max_len_i : StoreLimit;
    phase_d    = phase_q;
    key_pos_d  = key_pos_q;
    count_d    = count_q;
    final_done = 1'b0;
    have_a     = 1'b0;
    res_a      = '0;
    res_e      = '0;
    push_o     = '0;

    unique case (phase_q)
      PhKey: begin
        if (byte_i == key_char(key_pos_q) ||
            byte_i == (key_char(key_pos_q) ^ CaseBit)) begin
          if (key_pos_q == 2'd3) phase_d = PhPre;
          else key_pos_d = key_pos_q + 2'd1;
        end else begin
          have_a = 1'b1;
          res_a.kind = KindStatus;
          res_a.status = StNotEtag;
          final_done = 1'b1;
        end
      end
      PhPre: begin
        if (byte_i == ChColon) begin
          phase_d = PhPost;
        end else if (!ws) begin
          have_a = 1'b1;
          res_a.kind = KindStatus;
          res_a.status = StBad;
          final_done = 1'b1;
        end
      end
      PhPost, PhValue: begin
        priority if (phase_q == PhPost && ws) begin
          // skip whitespace after the colon
        end else if (phase_q == PhValue && (ws || byte_i == ChCr)) begin
          have_a = 1'b1;
          res_a.kind = KindStatus;
          res_a.status = StOk;
          res_a.len = count_q;
          final_done = 1'b1;
        end else if (count_q < limit) begin
          have_a = 1'b1;
          res_a.kind = KindByte;
          res_a.vbyte = byte_i;
          count_d = count_q + LenW'(1);
          phase_d = PhValue;
        end else begin
          have_a = 1'b1;
          res_a.kind = KindStatus;
          res_a.status = StLong;
          final_done = 1'b1;
        end
      end
      default: final_done = 1'b1;
    endcase

    // Early line end reports ok with the length so far
    res_e.kind   = KindStatus;
    res_e.status = StOk;
    res_e.len    = count_d;
    res_e.last   = 1'b1;

    if (line_end_i && !final_done) begin
      if (have_a) begin
        push_o.cnt  = 2'd2;
        push_o.res0 = res_a;
        push_o.res1 = res_e;
      end else begin
        push_o.cnt  = 2'd1;
        push_o.res0 = res_e;
      end
    end else if (have_a) begin
      push_o.cnt       = 2'd1;
      push_o.res0      = res_a;
      push_o.res0.last = 1'b1;
    end

    if (line_end_i) begin
      phase_d   = PhKey;
      key_pos_d = 2'd0;
      count_d   = '0;
    end else if (final_done) begin
      phase_d = PhDone;
    end

    if (!advance_i) push_o.cnt = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhKey;
      key_pos_q <= 2'd0;
      count_q   <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      key_pos_q <= key_pos_d;
      count_q   <= count_d;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= StoreLimit)
    else $error("value count beyond store limit");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> push_o.res0.kind == KindByte &&
                           push_o.res1.kind == KindStatus && push_o.res1.status == StOk)
    else $error("two results must be a value byte then an ok status");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && line_end_i |=> phase_q == PhKey && count_q == '0 && key_pos_q == 2'd0)
    else $error("line end did not re-arm the parser");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |-> push_o.cnt == 2'd0)
    else $error("result produced after final status");

endmodule

### src/ehfp_result_fifo.sv
// Result queue: takes up to two requests per cycle, delivers one per cycle unless the output stalls.
module ehfp_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ehfp_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ehfp_pkg::result_t out_o
);
  import ehfp_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  result_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q, count_d;
  logic            pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  // Room for a worst-case pair, counting this cycle's pop
  assign room_o      = ({1'b0, count_q} + 4'd2) <= (4'(Depth) + {3'b0, pop});
  assign count_d     = count_q + (PtrW+1)'(push_i.cnt) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.cnt);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> room_o)
    else $error("push without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])
    else $error("pointer and count disagree");

endmodule

### src/etag_header_field_parser.sv
// Top level of the ETag header field parser.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o | header_byte_i, line_end_i
//  out     | output    | out_valid_o / out_stall_i | result_kind_o, value_byte_o, status_o,
//          |           |                        | value_length_o, run_last_o
//  cfg     | input     | cfg_we_i               | cfg_data_i (max value length)
//
// One header byte is accepted per cycle while in_stall_o is low. An accepted
// byte sits in the input register, is decoded there, and its zero to two
// result requests land in a four-entry result queue in the same edge; the
// queue drives the output directly, with no register after the queue.
// A byte is held in the input register only while the queue lacks room for
// two results, so sustained rate is one byte per cycle as long as the output
// does not stall and the bytes average no more than one result each. Reset
// returns the parser to key matching, clears the queue and sets the length
// limit to 63; no clearing pass is needed.
module etag_header_field_parser #(
  parameter int unsigned VALUE_STORE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  header_byte_i,
  input  logic        line_end_i,
  // result requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  value_byte_o,
  output logic [1:0]  status_o,
  output logic [5:0]  value_length_o,
  output logic        run_last_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_data_i
);
  import ehfp_pkg::*;

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic [LenW-1:0] max_len_q;
  logic            room;
  logic            advance;
  push_t           push;
  result_t         head;

  // Decode the held byte when the queue can take its results
  assign advance    = in_valid_q && room;
  // Stall while the held byte cannot move on
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      max_len_q  <= LimitReset;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (cfg_we_i) max_len_q <= cfg_data_i;
    end
  end

  // Payload register: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= header_byte_i;
      in_last_q <= line_end_i;
    end
  end

  ehfp_parse_core #(
    .VALUE_STORE_BYTES(VALUE_STORE_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .byte_i     (in_byte_q),
    .line_end_i (in_last_q),
    .max_len_i  (max_len_q),
    .push_o     (push)
  );

  ehfp_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (head)
  );

  assign result_kind_o  = head.kind;
  assign value_byte_o   = head.vbyte;
  assign status_o       = head.status;
  assign value_length_o = head.len;
  assign run_last_o     = head.last;

endmodule

### tb/sv/tb_etag_header_field_parser.sv
// Self-checking testbench for the ETag header field parser: byte-level predictor plus scoreboard.
module tb_etag_header_field_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ehfp_pkg::*;

  localparam int unsigned ValueStoreBytes = 64;
  localparam int unsigned CycleLimit      = 400000;
  // Idle cycles to leave after the drain before touching the limit register.
  localparam int unsigned SettleCycles    = 6;
  localparam int unsigned RandomBytes     = 740;
  localparam logic [31:0] EtagKey         = "etag";

  typedef enum logic [2:0] {
    PhKey,
    PhPreColon,
    PhPostColon,
    PhValue,
    PhDone
  } parse_phase_e;

  // Drive every input to a known value from time zero.
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] header_byte_i = 8'h00;
  logic       line_end_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic       result_kind_o;
  logic [7:0] value_byte_o;
  logic [1:0] status_o;
  logic [5:0] value_length_o;
  logic       run_last_o;
  logic       cfg_we_i      = 1'b0;
  logic [5:0] cfg_data_i    = 6'd0;

  // Predictor copy of the parser state and the length limit register.
  parse_phase_e parse_phase = PhKey;
  logic [1:0]   key_pos     = 2'd0;
  logic [5:0]   value_cnt   = 6'd0;
  logic [5:0]   etag_limit  = LimitReset;

  result_t     expected_etag_results [$];
  logic [7:0]  line_buf [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  // Clear to run both sides back to back with no idle cycles.
  logic        idle_en        = 1'b1;

  etag_header_field_parser #(
    .VALUE_STORE_BYTES(ValueStoreBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .header_byte_i (header_byte_i),
    .line_end_i    (line_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .value_byte_o  (value_byte_o),
    .status_o      (status_o),
    .value_length_o(value_length_o),
    .run_last_o    (run_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bound the run; a hang ends as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic result_t make_status(input logic [1:0] st, input logic [5:0] len);
    result_t r;
    r = '0;
    r.kind   = KindStatus;
    r.status = st;
    r.len    = len;
    return r;
  endfunction

  function automatic result_t make_value_byte(input logic [7:0] c);
    result_t r;
    r = '0;
    r.kind  = KindByte;
    r.vbyte = c;
    return r;
  endfunction

  // Advance the predicted parser by one accepted byte and queue what it should emit.
  function automatic void parse_etag_byte(input logic [7:0] c, input logic eol);
    result_t    res [2];
    int unsigned n;
    logic       blank;
    logic       closed;
    logic [5:0] lim;
    logic [7:0] key_lc;
    n      = 0;
    blank  = (c == ChSpace) || (c == ChTab);
    closed = 1'b0;
    // The store caps the usable limit at one less than its size.
    lim    = (etag_limit < ValueStoreBytes - 1) ? etag_limit : 6'(ValueStoreBytes - 1);
    key_lc = EtagKey[31 - 8 * key_pos -: 8];
    case (parse_phase)
      PhKey: begin
        // Match either case of each key character.
        if (c == key_lc || c == (key_lc & ~CaseBit)) begin
          if (key_pos == 2'd3) parse_phase = PhPreColon;
          else key_pos = key_pos + 2'd1;
        end else begin
          res[n] = make_status(StNotEtag, 6'd0);
          n++;
          closed = 1'b1;
        end
      end
      PhPreColon: begin
        if (c == ChColon) begin
          parse_phase = PhPostColon;
        end else if (!blank) begin
          res[n] = make_status(StBad, 6'd0);
          n++;
          closed = 1'b1;
        end
      end
      PhPostColon, PhValue: begin
        // Skip blanks after the colon; the first other byte opens the value, CR included.
        if (!(parse_phase == PhPostColon && blank)) begin
          if (parse_phase == PhValue && (blank || c == ChCr)) begin
            res[n] = make_status(StOk, value_cnt);
            n++;
            closed = 1'b1;
          end else if (value_cnt < lim) begin
            res[n] = make_value_byte(c);
            n++;
            value_cnt   = value_cnt + 6'd1;
            parse_phase = PhValue;
          end else begin
            res[n] = make_status(StLong, 6'd0);
            n++;
            closed = 1'b1;
          end
        end
      end
      default: closed = 1'b1;
    endcase

    // A line end with no final status yet reports ok; any line end re-arms.
    if (eol) begin
      if (!closed) begin
        res[n] = make_status(StOk, value_cnt);
        n++;
      end
      parse_phase = PhKey;
      key_pos     = 2'd0;
      value_cnt   = 6'd0;
    end else if (closed) begin
      parse_phase = PhDone;
    end

    if (n > 0) res[n-1].last = 1'b1;
    for (int unsigned i = 0; i < n; i++) expected_etag_results.push_back(res[i]);
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_etag_result();
    result_t want;
    if (expected_etag_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d byte %0d status %0d len %0d",
               $time, result_kind_o, value_byte_o, status_o, value_length_o);
      mismatch_count++;
    end else begin
      want = expected_etag_results.pop_front();
      compare_field("result_kind", want.kind, result_kind_o);
      compare_field("value_byte", want.vbyte, value_byte_o);
      compare_field("status", want.status, status_o);
      compare_field("value_length", want.len, value_length_o);
      compare_field("run_last", want.last, run_last_o);
    end
  endfunction

  // Sample all three ports at the clock edge, before any of this edge's updates land.
  // Predict first so a request and its results can never be seen out of order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) etag_limit = cfg_data_i;
      if (in_valid_i && !in_stall_o) parse_etag_byte(header_byte_i, line_end_i);
      if (out_valid_o && !out_stall_i) check_etag_result();
    end
  end

  // Result side: hold stall for a drawn number of cycles, then take one request.
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = idle_en ? $urandom_range(0, 5) : 0;
      repeat (hold) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one header byte request; return at the edge where it is accepted.
  task automatic send_header_byte(input logic [7:0] b, input logic eol);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    header_byte_i <= b;
    line_end_i    <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Send the line buffer, marking its last byte as the line end.
  task automatic send_line();
    for (int unsigned i = 0; i < line_buf.size(); i++)
      send_header_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Drop valid and wait until every predicted result has come out, then let the block settle.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_etag_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [5:0] v);
    wait_results_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [7:0] random_blank();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  // Mixed-case key, blanks on both sides of the colon, value ends and the re-arm.
  task automatic test_value_framing();
    idle_en = 1'b1;
    // Value 0xFF closed by a space; the trailing byte carries the line end and is dropped.
    line_buf.delete();
    add_text("EtAg :\t");
    line_buf.push_back(8'hFF);
    add_text(" x");
    send_line();
    // A CR right after the colon is a value byte; the second CR closes the value.
    line_buf.delete();
    add_text("etag:");
    line_buf.push_back(ChCr);
    line_buf.push_back(8'h00);
    line_buf.push_back(ChCr);
    send_line();
    // Line end on a value byte: the byte and the ok status from one request.
    line_buf.delete();
    add_text("ETAG:v");
    send_line();
  endtask

  // Wrong key, junk before the colon and lines that stop early.
  task automatic test_error_status();
    line_buf.delete();
    add_text("x");
    send_line();
    line_buf.delete();
    add_text("e");
    send_line();
    line_buf.delete();
    add_text("etag z");
    send_line();
    line_buf.delete();
    add_text("etaG");
    send_line();
  endtask

  // Too long values at the smallest limits, then restore the widest limit.
  task automatic test_length_limit();
    write_limit(6'd1);
    line_buf.delete();
    add_text("etag:ab");
    send_line();
    write_limit(6'd0);
    line_buf.delete();
    add_text("etag:q");
    send_line();
    write_limit(LimitReset);
  endtask

  // Mostly well-formed lines with random content; some broken, cut short or pure noise.
  task automatic build_random_line();
    int unsigned vlen;
    int unsigned cut;
    logic [7:0]  b;
    line_buf.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom));
      return;
    end
    for (int i = 0; i < 4; i++) begin
      b = EtagKey[31 - 8 * i -: 8];
      if ($urandom_range(0, 1) != 0) b = b & ~CaseBit;
      if ($urandom_range(0, 29) == 0) b = 8'($urandom);
      line_buf.push_back(b);
    end
    repeat ($urandom_range(0, 2)) line_buf.push_back(random_blank());
    line_buf.push_back(($urandom_range(0, 24) == 0) ? 8'($urandom) : ChColon);
    repeat ($urandom_range(0, 2)) line_buf.push_back(random_blank());
    // Keep most values short; now and then run past the limit in force.
    vlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, etag_limit + 2) : $urandom_range(0, 6);
    for (int unsigned i = 0; i < vlen; i++) begin
      b = 8'($urandom);
      if (i == 0) begin
        if ($urandom_range(0, 15) == 0) b = ChCr;
      end else begin
        while (b == ChSpace || b == ChTab || b == ChCr) b = 8'($urandom);
      end
      line_buf.push_back(b);
    end
    case ($urandom_range(0, 3))
      0: line_buf.push_back(ChSpace);
      1: line_buf.push_back(ChTab);
      2: line_buf.push_back(ChCr);
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, line_buf.size());
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end
  endtask

  task automatic test_random_lines();
    int unsigned sent;
    logic [5:0]  lim;
    sent = 0;
    for (int unsigned k = 0; k < 8; k++) begin
      case (k)
        0: lim = LenMax;
        1: lim = 6'd1;
        2: lim = 6'd0;
        3: lim = 6'd2;
        default: lim = 6'($urandom_range(0, 63));
      endcase
      write_limit(lim);
      while (sent < (k + 1) * RandomBytes / 8) begin
        idle_en = ($urandom_range(0, 3) != 0);
        build_random_line();
        send_line();
        sent += line_buf.size();
        // Now and then hold the sender until the output side has caught up.
        if ($urandom_range(0, 29) == 0) wait_results_drained();
      end
    end
  endtask

  initial begin : main
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_value_framing();
    test_error_status();
    test_length_limit();
    test_random_lines();
    idle_en = 1'b1;
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
src/ehfp_pkg.sv
src/ehfp_parse_core.sv
src/ehfp_result_fifo.sv
src/etag_header_field_parser.sv
tb/sv/tb_etag_header_field_parser.sv
